@@ hdl/msr_pkg.sv @@
// ----------------------------------------------------------------------------
// msr_pkg
// Shared types and constants for the multi-channel servo ramp.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int unsigned Channels  = 16;
  localparam int unsigned PulseBits = 12;
  localparam int unsigned TickMs    = 10;

  localparam int unsigned ChW     = 4;
  localparam int unsigned DurW    = 16;
  localparam int unsigned KmW     = DurW + 1;
  localparam int unsigned ProdW   = KmW + PulseBits;
  localparam int unsigned DivCntW = $clog2(PulseBits);

  localparam logic [1:0] OpLoad  = 2'd0;
  localparam logic [1:0] OpStart = 2'd1;
  localparam logic [1:0] OpTick  = 2'd2;
  localparam logic [1:0] OpNone  = 2'd3;

  typedef struct packed {
    logic [1:0]      op;
    logic [3:0]      channel;
    logic [11:0]     pulse;
    logic [DurW-1:0] duration_ms;
  } req_t;

  typedef struct packed {
    logic [3:0]  servo_channel;
    logic [11:0] pulse_value;
    logic        last_of_run;
  } rsp_t;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StRead = 5'b00010,
    StMul  = 5'b00100,
    StDiv  = 5'b01000,
    StPut  = 5'b10000
  } state_e;

endpackage

@@ hdl/multi_channel_servo_ramp.sv @@
// ----------------------------------------------------------------------------
// multi_channel_servo_ramp
// Sixteen-channel linear servo ramp with exact integer interpolation.
// ----------------------------------------------------------------------------
// Loads, start setup and idle ticks are handled in idle; ready is high in idle.
// A ramp tick takes each channel through read, 17x12 multiply, 12-step shared
// restoring divider and output, one channel after another for all sixteen.
// A final burst (last tick or short move) goes from read straight to output.
// Output stalls extend the burst. Reset clears all positions and the move state.
module multi_channel_servo_ramp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  msr_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output msr_pkg::rsp_t out_rsp_o
);

  msr_pkg::state_e state_q, state_d;

  logic [msr_pkg::PulseBits-1:0] start_q  [msr_pkg::Channels];
  logic [msr_pkg::PulseBits-1:0] target_q [msr_pkg::Channels];

  logic                          moving_q;
  logic [msr_pkg::KmW-1:0]       km_q;
  logic [msr_pkg::DurW-1:0]      dur_q;
  logic                          final_q;
  logic [msr_pkg::ChW-1:0]       ch_q;
  logic [msr_pkg::PulseBits-1:0] s_q, t_q, mag_q;
  logic                          neg_q;
  logic [msr_pkg::DurW-1:0]      rem_q;
  logic [msr_pkg::PulseBits-1:0] quo_q;
  logic [msr_pkg::DivCntW-1:0]   cnt_q;
  logic                          out_valid_q;
  msr_pkg::rsp_t                 out_q;

  logic                          in_fire;
  logic                          put_fire;
  logic                          last_ch;
  logic [msr_pkg::KmW-1:0]       km_next;
  logic                          tick_final;
  logic [msr_pkg::PulseBits:0]   diff;
  logic [msr_pkg::PulseBits:0]   diff_mag;
  logic [msr_pkg::ProdW-1:0]     prod;
  logic [msr_pkg::DurW:0]        trial;
  logic                          ge;
  logic [msr_pkg::DurW:0]        trial_sub;
  logic [msr_pkg::PulseBits-1:0] value;

  assign in_ready_o  = (state_q == msr_pkg::StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign put_fire    = (state_q == msr_pkg::StPut) && (!out_valid_q || out_ready_i);
  assign last_ch     = (ch_q == msr_pkg::ChW'(msr_pkg::Channels - 1));
  assign km_next     = km_q + msr_pkg::KmW'(msr_pkg::TickMs);
  assign tick_final  = (km_next >= {1'b0, dur_q});

  assign diff     = {1'b0, target_q[ch_q]} - {1'b0, start_q[ch_q]};
  assign diff_mag = diff[msr_pkg::PulseBits] ? (~diff + 1'b1) : diff;
  assign prod     = msr_pkg::ProdW'(km_q) * msr_pkg::ProdW'(mag_q);

  assign trial     = {rem_q, quo_q[msr_pkg::PulseBits-1]};
  assign ge        = (trial >= {1'b0, dur_q});
  assign trial_sub = trial - {1'b0, dur_q};

  always_comb begin
    if (final_q) begin
      value = t_q;
    end else if (neg_q) begin
      value = s_q - quo_q;
    end else begin
      value = s_q + quo_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      msr_pkg::StIdle: begin
        if (in_fire) begin
          if (in_req_i.op == msr_pkg::OpStart &&
              in_req_i.duration_ms <= msr_pkg::DurW'(msr_pkg::TickMs)) begin
            state_d = msr_pkg::StRead;
          end else if (in_req_i.op == msr_pkg::OpTick && moving_q) begin
            state_d = msr_pkg::StRead;
          end
        end
      end
      msr_pkg::StRead: state_d = final_q ? msr_pkg::StPut : msr_pkg::StMul;
      msr_pkg::StMul:  state_d = msr_pkg::StDiv;
      msr_pkg::StDiv: begin
        if (cnt_q == '0) begin
          state_d = msr_pkg::StPut;
        end
      end
      msr_pkg::StPut: begin
        if (put_fire) begin
          state_d = last_ch ? msr_pkg::StIdle : msr_pkg::StRead;
        end
      end
      default: state_d = msr_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msr_pkg::StIdle;
      moving_q    <= 1'b0;
      km_q        <= '0;
      dur_q       <= '0;
      final_q     <= 1'b0;
      ch_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < msr_pkg::Channels; i++) begin
        start_q[i]  <= '0;
        target_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (put_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        msr_pkg::StIdle: begin
          ch_q <= '0;
          if (in_fire) begin
            case (in_req_i.op)
              msr_pkg::OpLoad: begin
                target_q[in_req_i.channel] <= in_req_i.pulse;
              end
              msr_pkg::OpStart: begin
                km_q <= '0;
                if (in_req_i.duration_ms <= msr_pkg::DurW'(msr_pkg::TickMs)) begin
                  moving_q <= 1'b0;
                  final_q  <= 1'b1;
                end else begin
                  moving_q <= 1'b1;
                  dur_q    <= in_req_i.duration_ms;
                end
              end
              msr_pkg::OpTick: begin
                if (moving_q) begin
                  if (tick_final) begin
                    moving_q <= 1'b0;
                    km_q     <= '0;
                    final_q  <= 1'b1;
                  end else begin
                    km_q    <= km_next;
                    final_q <= 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        msr_pkg::StDiv: begin
          cnt_q <= cnt_q - 1'b1;
        end
        msr_pkg::StMul: begin
          cnt_q <= msr_pkg::DivCntW'(msr_pkg::PulseBits - 1);
        end
        msr_pkg::StPut: begin
          if (put_fire) begin
            ch_q <= ch_q + 1'b1;
            if (final_q) begin
              start_q[ch_q] <= t_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      msr_pkg::StRead: begin
        s_q   <= start_q[ch_q];
        t_q   <= target_q[ch_q];
        neg_q <= diff[msr_pkg::PulseBits];
        mag_q <= diff_mag[msr_pkg::PulseBits-1:0];
      end
      msr_pkg::StMul: begin
        rem_q <= prod[msr_pkg::PulseBits +: msr_pkg::DurW];
        quo_q <= prod[msr_pkg::PulseBits-1:0];
      end
      msr_pkg::StDiv: begin
        rem_q <= ge ? trial_sub[msr_pkg::DurW-1:0] : trial[msr_pkg::DurW-1:0];
        quo_q <= {quo_q[msr_pkg::PulseBits-2:0], ge};
      end
      msr_pkg::StPut: begin
        if (put_fire) begin
          out_q.servo_channel <= ch_q;
          out_q.pulse_value   <= value;
          out_q.last_of_run   <= last_ch;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");

  a_move_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    moving_q |-> (km_q < {1'b0, dur_q}) && (dur_q > msr_pkg::DurW'(msr_pkg::TickMs)))
    else $error("move step out of range");

  a_rem_below_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msr_pkg::StDiv) |-> (rem_q < dur_q))
    else $error("divider remainder overflow");

  a_burst_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (put_fire && last_ch) |=> (state_q == msr_pkg::StIdle) && out_valid_q &&
      out_q.last_of_run)
    else $error("burst did not close");

  a_ramp_has_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msr_pkg::StMul) |-> !final_q)
    else $error("final burst entered divider");

endmodule

@@ sim/multi_channel_servo_ramp_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_servo_ramp_tb
// Self-checking testbench for the sixteen-channel servo ramp. Directed tests
// cover target loads, short moves, multi-tick ramps, loads and restarts during
// a move, idle ticks and the unused op. Randomized move sequences then run
// under several sender and receiver idle patterns. Every burst is predicted
// with exact integer interpolation and checked per channel, in order.
// ----------------------------------------------------------------------------
module multi_channel_servo_ramp_tb;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned TailCycles = 600;
  localparam int unsigned ReportMax  = 10;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  msr_pkg::req_t in_req_i;
  logic          out_valid_o;
  logic          out_ready_i;
  msr_pkg::rsp_t out_rsp_o;

  multi_channel_servo_ramp dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // predictor state
  logic [msr_pkg::PulseBits-1:0] start_pos  [msr_pkg::Channels];
  logic [msr_pkg::PulseBits-1:0] target_pos [msr_pkg::Channels];
  int unsigned                   step_idx;
  int unsigned                   move_dur;
  bit                            moving;

  msr_pkg::rsp_t pulse_q[$];
  int unsigned   cycle_count;
  int unsigned   mismatches;
  int unsigned   requests_sent;
  int unsigned   active_requests;
  int unsigned   pulses_checked;
  int unsigned   bursts_checked;
  int unsigned   sender_idle_pct;
  int unsigned   rx_stall_pct;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic void push_burst(bit at_target, int unsigned k);
    longint        s;
    longint        t;
    longint        num;
    longint        v;
    msr_pkg::rsp_t r;
    for (int ch = 0; ch < msr_pkg::Channels; ch++) begin
      s = longint'(start_pos[ch]);
      t = longint'(target_pos[ch]);
      if (at_target) begin
        v = t;
      end else begin
        num = longint'(k) * longint'(msr_pkg::TickMs) * (t - s);
        if (num < 0) v = s - ((-num) / longint'(move_dur));
        else v = s + (num / longint'(move_dur));
      end
      r.servo_channel = ch[3:0];
      r.pulse_value   = v[msr_pkg::PulseBits-1:0];
      r.last_of_run   = (ch == msr_pkg::Channels - 1);
      pulse_q.push_back(r);
    end
  endfunction

  function automatic void settle_positions();
    for (int ch = 0; ch < msr_pkg::Channels; ch++) start_pos[ch] = target_pos[ch];
    moving   = 1'b0;
    step_idx = 0;
  endfunction

  // returns 1 when the request changes state or causes a burst
  function automatic bit predict_request(msr_pkg::req_t r);
    int unsigned ticks;
    int unsigned k;
    case (r.op)
      msr_pkg::OpLoad: begin
        if (r.channel < msr_pkg::Channels)
          target_pos[r.channel] = r.pulse[msr_pkg::PulseBits-1:0];
        return 1'b1;
      end
      msr_pkg::OpStart: begin
        if (r.duration_ms <= msr_pkg::TickMs) begin
          push_burst(1'b1, 0);
          settle_positions();
        end else begin
          move_dur = r.duration_ms;
          step_idx = 0;
          moving   = 1'b1;
        end
        return 1'b1;
      end
      msr_pkg::OpTick: begin
        if (!moving || move_dur <= msr_pkg::TickMs) return 1'b0;
        ticks = (move_dur + msr_pkg::TickMs - 1) / msr_pkg::TickMs;
        k     = step_idx + 1;
        if (k >= ticks) begin
          push_burst(1'b1, k);
          settle_positions();
        end else begin
          push_burst(1'b0, k);
          step_idx = k;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_request(msr_pkg::req_t r);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < sender_idle_pct) gap = $urandom_range(1, 8);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = r;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
    if (predict_request(r)) active_requests++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pulse_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_target(logic [3:0] ch, logic [11:0] p);
    msr_pkg::req_t r;
    r = '0;
    r.op      = msr_pkg::OpLoad;
    r.channel = ch;
    r.pulse   = p;
    send_request(r);
  endtask

  task automatic start_move(logic [15:0] d);
    msr_pkg::req_t r;
    r = '0;
    r.op          = msr_pkg::OpStart;
    r.duration_ms = d;
    send_request(r);
  endtask

  task automatic send_tick();
    msr_pkg::req_t r;
    r = '0;
    r.op = msr_pkg::OpTick;
    send_request(r);
  endtask

  function automatic logic [11:0] pick_pulse();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 12'd0;
    if (sel == 1) return 12'hfff;
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [15:0] pick_duration();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel <= 2) return 16'($urandom_range(0, msr_pkg::TickMs));
    if (sel == 3) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(msr_pkg::TickMs + 1, 150));
  endfunction

  function automatic msr_pkg::req_t noise_request();
    msr_pkg::req_t r;
    r.op          = 2'($urandom_range(0, 3));
    r.channel     = 4'($urandom_range(0, 15));
    r.pulse       = 12'($urandom_range(0, 4095));
    r.duration_ms = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  task automatic test_idle_and_unused();
    msr_pkg::req_t r;
    send_tick();
    r = '1;
    send_request(r);
    r = '0;
    r.op = msr_pkg::OpNone;
    send_request(r);
    wait_drained();
  endtask

  task automatic test_short_move();
    load_target(4'd0, 12'hfff);
    load_target(4'd15, 12'hfff);
    load_target(4'd7, 12'haaa);
    load_target(4'd8, 12'h555);
    start_move(16'd0);
    load_target(4'd0, 12'd0);
    start_move(16'd10);
    wait_drained();
  endtask

  task automatic test_ramp();
    load_target(4'd15, 12'd0);
    load_target(4'd3, 12'hfff);
    start_move(16'd25);
    repeat (4) send_tick();
    load_target(4'd1, 12'd1);
    start_move(16'd11);
    repeat (2) send_tick();
    wait_drained();
  endtask

  task automatic test_load_during_move();
    load_target(4'd5, 12'd0);
    start_move(16'd40);
    send_tick();
    load_target(4'd5, 12'd1234);
    repeat (3) send_tick();
    wait_drained();
  endtask

  task automatic test_restart_during_move();
    load_target(4'd9, 12'hfff);
    start_move(16'hffff);
    repeat (2) send_tick();
    start_move(16'd30);
    repeat (3) send_tick();
    wait_drained();
  endtask

  task automatic test_random_phase(int unsigned idle, int unsigned stall, int unsigned quota);
    int unsigned base;
    int unsigned kind;
    int unsigned nticks;
    logic [15:0] d;
    sender_idle_pct = idle;
    rx_stall_pct    = stall;
    base            = active_requests;
    while (active_requests - base < quota) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        repeat ($urandom_range(1, 4)) load_target(4'($urandom_range(0, 15)), pick_pulse());
        d = pick_duration();
        start_move(d);
        nticks = (d <= msr_pkg::TickMs) ? 0 : (d + msr_pkg::TickMs - 1) / msr_pkg::TickMs;
        if (nticks > 15) nticks = $urandom_range(1, 4);
        repeat (nticks) begin
          if ($urandom_range(0, 7) == 0)
            load_target(4'($urandom_range(0, 15)), pick_pulse());
          send_tick();
        end
      end else if (kind == 7) begin
        send_request(noise_request());
      end else if (kind == 8) begin
        send_tick();
      end else begin
        start_move(16'($urandom_range(msr_pkg::TickMs + 1, 200)));
        repeat ($urandom_range(0, 3)) send_tick();
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    msr_pkg::rsp_t exp_rsp;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d pulses outstanding", cycle_count,
               pulse_q.size());
      $display("status: fail");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pulse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected pulse: ch %0d value %0d last %0b", out_rsp_o.servo_channel,
                   out_rsp_o.pulse_value, out_rsp_o.last_of_run);
      end else begin
        exp_rsp = pulse_q.pop_front();
        pulses_checked++;
        if (out_rsp_o.last_of_run) bursts_checked++;
        if (out_rsp_o.servo_channel !== exp_rsp.servo_channel ||
            out_rsp_o.pulse_value !== exp_rsp.pulse_value ||
            out_rsp_o.last_of_run !== exp_rsp.last_of_run) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("pulse mismatch: exp ch %0d value %0d last %0b, got ch %0d value %0d last %0b",
                     exp_rsp.servo_channel, exp_rsp.pulse_value, exp_rsp.last_of_run,
                     out_rsp_o.servo_channel, out_rsp_o.pulse_value, out_rsp_o.last_of_run);
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_req_i        = '0;
    out_ready_i     = 1'b0;
    cycle_count     = 0;
    mismatches      = 0;
    requests_sent   = 0;
    active_requests = 0;
    pulses_checked  = 0;
    bursts_checked  = 0;
    sender_idle_pct = 0;
    rx_stall_pct    = 0;
    step_idx        = 0;
    move_dur        = 0;
    moving          = 1'b0;
    for (int ch = 0; ch < msr_pkg::Channels; ch++) begin
      start_pos[ch]  = '0;
      target_pos[ch] = '0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_and_unused();
    test_short_move();
    test_ramp();
    test_load_during_move();
    test_restart_during_move();
    test_random_phase(0, 0, 75);
    test_random_phase(56, 0, 75);
    test_random_phase(0, 56, 75);
    test_random_phase(9, 9, 75);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pulse_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (pulse_q.size() != 0) mismatches++;

    $display("sent %0d requests (%0d not ignored) over four idle/stall patterns",
             requests_sent, active_requests);
    $display("checked %0d channel pulses in %0d bursts, %0d mismatches",
             pulses_checked, bursts_checked, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
